### design/pptb_pkg.sv
// Package for the plain PPM text-to-bytes block: result type, parser and
// comment-mode codes, tag word characters and the decimal accumulate step.
// No dependencies.
`default_nettype none

package pptb_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_WIDTH  = 3'd1,
        PH_HEIGHT = 3'd2,
        PH_MAXVAL = 3'd3,
        PH_COMP   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        CM_NONE      = 3'd0,
        CM_LEAD      = 3'd1,
        CM_PREFIX    = 3'd2,
        CM_BYTES     = 3'd3,
        CM_BITS      = 3'd4,
        CM_NUM_BYTES = 3'd5,
        CM_NUM_BITS  = 3'd6,
        CM_SKIP      = 3'd7
    } cmode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_MAGIC   = 3'd1,
        ST_SIZE    = 3'd2,
        ST_MAXVAL  = 3'd3,
        ST_COMP    = 3'd4,
        ST_EARLY   = 3'd5,
        ST_BYTETAG = 3'd6,
        ST_BITTAG  = 3'd7
    } status_t;

    localparam logic KIND_COMP    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_HIGH  = 8'h80;

    localparam logic [3:0] PREFIX_LEN    = 4'd10;
    localparam logic [3:0] TAG_SPLIT_POS = 4'd11;
    localparam logic [3:0] BYTES_LEN     = 4'd14;
    localparam logic [3:0] BITS_LEN      = 4'd13;

    localparam logic [63:0] DEC_LIMIT = 64'd1844674407370955161;
    localparam logic [63:0] MAXVAL    = 64'd255;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value;
        logic [33:0] index;
        logic [2:0]  status;
        logic [33:0] bytes;
        logic [36:0] bits;
    } pptb_result_t;

    // byte-count tag word, one character per position
    function automatic logic [7:0] bytes_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h4D;
            4'd1:    c = 8'h41;
            4'd2:    c = 8'h4B;
            4'd3:    c = 8'h4F;
            4'd4:    c = 8'h43;
            4'd5:    c = 8'h4F;
            4'd6:    c = 8'h44;
            4'd7:    c = 8'h45;
            4'd8:    c = 8'h5F;
            4'd9:    c = 8'h42;
            4'd10:   c = 8'h59;
            4'd11:   c = 8'h54;
            4'd12:   c = 8'h45;
            4'd13:   c = 8'h53;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // bit-count tag word shares the first ten characters
    function automatic logic [7:0] bits_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd10:   c = 8'h49;
            4'd11:   c = 8'h54;
            4'd12:   c = 8'h53;
            4'd13:   c = 8'h00;
            4'd14:   c = 8'h00;
            4'd15:   c = 8'h00;
            default: c = bytes_char(pos);
        endcase
        return c;
    endfunction

    // returns {ok, value}; value holds on overflow
    function automatic logic [64:0] dec_push(input logic [63:0] v, input logic [3:0] d);
        logic ok;
        logic [63:0] nv;
        ok = !((v > DEC_LIMIT) || ((v == DEC_LIMIT) && (d > 4'd5)));
        nv = ok ? ((v << 3) + (v << 1) + {60'd0, d}) : v;
        return {ok, nv};
    endfunction

endpackage

`default_nettype wire

### design/pptb_parser.sv
// Token, header and comment-tag state for the PPM text parser. One byte
// per go cycle; gives up to two results. Depends on pptb_pkg.
`default_nettype none

module pptb_parser #(
    parameter int DIM_BITS = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   go,
    input  wire [7:0]             text_byte,
    input  wire                   end_of_text,
    output logic                  res0_valid,
    output pptb_pkg::pptb_result_t res0,
    output logic                  res1_valid,
    output pptb_pkg::pptb_result_t res1
);
    import pptb_pkg::*;

    localparam int TOT_W = 2 * DIM_BITS + 2;

    phase_t             phase_reg, phase_next;
    logic               in_token_reg, in_token_next;
    logic [63:0]        token_value_reg, token_value_next;
    logic               token_bad_reg, token_bad_next;
    logic [1:0]         mpos_reg, mpos_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [TOT_W-1:0]   emitted_reg, emitted_next;
    cmode_t             cmode_reg, cmode_next;
    logic [3:0]         tpos_reg, tpos_next;
    logic [63:0]        tag_value_reg, tag_value_next;
    logic [1:0]         tag_ok_reg, tag_ok_next;
    logic               bseen_reg, bseen_next;
    logic [63:0]        bval_reg, bval_next;
    logic               tseen_reg, tseen_next;
    logic [63:0]        tval_reg, tval_next;

    function automatic pptb_result_t make_summary(
        input logic [2:0]       st_in,
        input logic [TOT_W-1:0] emitted,
        input logic [TOT_W-1:0] total,
        input logic             bseen,
        input logic [63:0]      bval,
        input logic             tseen,
        input logic [63:0]      tval
    );
        pptb_result_t r;
        logic [2:0]  st;
        logic [63:0] tot64;
        logic [63:0] nb;
        logic [63:0] nbits;
        st    = st_in;
        tot64 = 64'(total);
        nb    = 64'd0;
        nbits = 64'd0;
        if (st == ST_OK) begin
            nb = tot64;
            if (bseen) begin
                if (bval > tot64)
                    st = ST_BYTETAG;
                else
                    nb = bval;
            end
            if (st == ST_OK) begin
                if (tseen) begin
                    if (tval > (nb << 3))
                        st = ST_BITTAG;
                    else
                        nbits = tval;
                end
                else begin
                    nbits = nb << 3;
                end
            end
            if (st != ST_OK) begin
                nb    = 64'd0;
                nbits = 64'd0;
            end
        end
        r.kind   = KIND_SUMMARY;
        r.value  = 8'd0;
        r.index  = 34'(64'(emitted));
        r.status = st;
        r.bytes  = nb[33:0];
        r.bits   = nbits[36:0];
        return r;
    endfunction

    always_comb
    begin
        logic             blank;
        logic             digit;
        logic             delim;
        logic             do_end;
        logic             hash_pend;
        logic             lead_hold;
        logic             dim_ok;
        logic [64:0]      pushed;
        logic [3:0]       tlen;
        logic [7:0]       tch;
        logic [2*DIM_BITS-1:0] prod;
        pptb_result_t     pend;
        logic             pend_valid;

        phase_next       = phase_reg;
        in_token_next    = in_token_reg;
        token_value_next = token_value_reg;
        token_bad_next   = token_bad_reg;
        mpos_next        = mpos_reg;
        width_next       = width_reg;
        total_next       = total_reg;
        emitted_next     = emitted_reg;
        cmode_next       = cmode_reg;
        tpos_next        = tpos_reg;
        tag_value_next   = tag_value_reg;
        tag_ok_next      = tag_ok_reg;
        bseen_next       = bseen_reg;
        bval_next        = bval_reg;
        tseen_next       = tseen_reg;
        tval_next        = tval_reg;

        res0_valid = 1'b0;
        res1_valid = 1'b0;
        res0       = '0;
        res1       = '0;
        pend       = '0;
        pend_valid = 1'b0;

        blank     = (text_byte == CH_SPACE) || (text_byte == CH_TAB);
        digit     = (text_byte >= CH_0) && (text_byte <= CH_9);
        delim     = (text_byte <= CH_SPACE) || (text_byte >= CH_HIGH);
        do_end    = 1'b0;
        hash_pend = 1'b0;
        lead_hold = 1'b0;
        pushed    = dec_push(token_value_reg, text_byte[3:0]);
        tlen      = BYTES_LEN;
        tch       = 8'd0;
        prod      = '0;
        dim_ok    = 1'b0;

        if (phase_reg == PH_DONE) begin
            // drop everything up to the frame end
        end
        else if (cmode_reg != CM_NONE) begin
            if ((text_byte == CH_LF) || (text_byte == CH_CR)) begin
                if (tag_ok_reg == 2'd1) begin
                    if (cmode_reg == CM_NUM_BYTES) begin
                        bseen_next = 1'b1;
                        bval_next  = tag_value_reg;
                    end
                    else if (cmode_reg == CM_NUM_BITS) begin
                        tseen_next = 1'b1;
                        tval_next  = tag_value_reg;
                    end
                end
                cmode_next = CM_NONE;
            end
            else begin
                if (cmode_reg == CM_LEAD) begin
                    if (blank) begin
                        lead_hold = 1'b1;
                    end
                    else begin
                        cmode_next = CM_PREFIX;
                        tpos_next  = 4'd0;
                    end
                end
                if (!lead_hold) begin
                    unique case (cmode_next)
                        CM_PREFIX:
                        begin
                            if (tpos_next < PREFIX_LEN) begin
                                if (text_byte == bytes_char(tpos_next))
                                    tpos_next = tpos_next + 4'd1;
                                else
                                    cmode_next = CM_SKIP;
                            end
                            else if (text_byte == CH_Y) begin
                                cmode_next = CM_BYTES;
                                tpos_next  = TAG_SPLIT_POS;
                            end
                            else if (text_byte == CH_I) begin
                                cmode_next = CM_BITS;
                                tpos_next  = TAG_SPLIT_POS;
                            end
                            else begin
                                cmode_next = CM_SKIP;
                            end
                        end
                        CM_BYTES, CM_BITS:
                        begin
                            tlen = (cmode_next == CM_BYTES) ? BYTES_LEN : BITS_LEN;
                            tch  = (cmode_next == CM_BYTES) ? bytes_char(tpos_next)
                                                            : bits_char(tpos_next);
                            if ((tpos_next < tlen) && (text_byte == tch)) begin
                                tpos_next = tpos_next + 4'd1;
                                if (tpos_next == tlen) begin
                                    cmode_next = (cmode_next == CM_BYTES) ? CM_NUM_BYTES
                                                                          : CM_NUM_BITS;
                                    tag_value_next = 64'd0;
                                    tag_ok_next    = 2'd0;
                                end
                            end
                            else begin
                                cmode_next = CM_SKIP;
                            end
                        end
                        CM_NUM_BYTES, CM_NUM_BITS:
                        begin
                            if (digit) begin
                                if (tag_ok_reg != 2'd2) begin
                                    pushed = dec_push(tag_value_reg, text_byte[3:0]);
                                    tag_ok_next = pushed[64] ? 2'd1 : 2'd2;
                                    tag_value_next = pushed[63:0];
                                end
                            end
                            else if (!(blank && (tag_ok_reg == 2'd0))) begin
                                if (tag_ok_reg == 2'd1) begin
                                    if (cmode_reg == CM_NUM_BYTES) begin
                                        bseen_next = 1'b1;
                                        bval_next  = tag_value_reg;
                                    end
                                    else begin
                                        tseen_next = 1'b1;
                                        tval_next  = tag_value_reg;
                                    end
                                end
                                cmode_next = CM_SKIP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        else if (text_byte == CH_HASH) begin
            do_end    = in_token_reg;
            hash_pend = 1'b1;
        end
        else if (delim) begin
            do_end = in_token_reg;
        end
        else begin
            if (!in_token_reg) begin
                in_token_next    = 1'b1;
                token_value_next = 64'd0;
                token_bad_next   = 1'b0;
                mpos_next        = 2'd0;
            end
            if (phase_reg == PH_MAGIC) begin
                if ((mpos_next == 2'd0) && (text_byte == CH_P))
                    mpos_next = 2'd1;
                else if ((mpos_next == 2'd1) && (text_byte == CH_3))
                    mpos_next = 2'd2;
                else
                    token_bad_next = 1'b1;
            end
            else if (digit) begin
                pushed = dec_push(token_value_next, text_byte[3:0]);
                if (!token_bad_next) begin
                    if (pushed[64])
                        token_value_next = pushed[63:0];
                    else
                        token_bad_next = 1'b1;
                end
            end
            else begin
                token_bad_next = 1'b1;
            end
        end

        // end of stream closes a pending token
        if (end_of_text && (phase_reg != PH_DONE) && in_token_next)
            do_end = 1'b1;

        if (do_end) begin
            dim_ok = !token_bad_next && (token_value_next != 64'd0) &&
                     ((token_value_next >> DIM_BITS) == 64'd0);
            in_token_next = 1'b0;
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (token_bad_next || (mpos_next != 2'd2)) begin
                        pend = make_summary(ST_MAGIC, emitted_next, total_next,
                                            bseen_next, bval_next, tseen_next, tval_next);
                        pend_valid = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else begin
                        phase_next = PH_WIDTH;
                    end
                end
                PH_WIDTH:
                begin
                    if (!dim_ok) begin
                        pend = make_summary(ST_SIZE, emitted_next, total_next,
                                            bseen_next, bval_next, tseen_next, tval_next);
                        pend_valid = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else begin
                        width_next = token_value_next[DIM_BITS-1:0];
                        phase_next = PH_HEIGHT;
                    end
                end
                PH_HEIGHT:
                begin
                    if (!dim_ok) begin
                        pend = make_summary(ST_SIZE, emitted_next, total_next,
                                            bseen_next, bval_next, tseen_next, tval_next);
                        pend_valid = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else begin
                        prod       = width_reg * token_value_next[DIM_BITS-1:0];
                        total_next = (TOT_W'(prod) << 1) + TOT_W'(prod);
                        phase_next = PH_MAXVAL;
                    end
                end
                PH_MAXVAL:
                begin
                    if (token_bad_next || (token_value_next != MAXVAL)) begin
                        pend = make_summary(ST_MAXVAL, emitted_next, total_next,
                                            bseen_next, bval_next, tseen_next, tval_next);
                        pend_valid = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else begin
                        phase_next = PH_COMP;
                    end
                end
                PH_COMP:
                begin
                    if (token_bad_next || (token_value_next > MAXVAL)) begin
                        pend = make_summary(ST_COMP, emitted_next, total_next,
                                            bseen_next, bval_next, tseen_next, tval_next);
                        pend_valid = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else begin
                        res0_valid   = 1'b1;
                        res0.kind    = KIND_COMP;
                        res0.value   = token_value_next[7:0];
                        res0.index   = 34'(64'(emitted_reg));
                        res0.status  = ST_OK;
                        res0.bytes   = 34'd0;
                        res0.bits    = 37'd0;
                        emitted_next = emitted_reg + 1'b1;
                        if (emitted_next == total_next) begin
                            pend = make_summary(ST_OK, emitted_next, total_next,
                                                bseen_next, bval_next, tseen_next,
                                                tval_next);
                            pend_valid = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (hash_pend && (phase_next != PH_DONE)) begin
            cmode_next     = CM_LEAD;
            tpos_next      = 4'd0;
            tag_value_next = 64'd0;
            tag_ok_next    = 2'd0;
        end

        if (end_of_text && (phase_next != PH_DONE) && !pend_valid) begin
            pend = make_summary(ST_EARLY, emitted_next, total_next,
                                bseen_next, bval_next, tseen_next, tval_next);
            pend_valid = 1'b1;
        end

        // place the summary after any component
        if (pend_valid) begin
            if (res0_valid) begin
                res1_valid = 1'b1;
                res1       = pend;
            end
            else begin
                res0_valid = 1'b1;
                res0       = pend;
            end
        end

        if (end_of_text) begin
            phase_next       = PH_MAGIC;
            in_token_next    = 1'b0;
            token_value_next = 64'd0;
            token_bad_next   = 1'b0;
            mpos_next        = 2'd0;
            width_next       = '0;
            total_next       = '0;
            emitted_next     = '0;
            cmode_next       = CM_NONE;
            tpos_next        = 4'd0;
            tag_value_next   = 64'd0;
            tag_ok_next      = 2'd0;
            bseen_next       = 1'b0;
            bval_next        = 64'd0;
            tseen_next       = 1'b0;
            tval_next        = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_MAGIC;
            in_token_reg    <= 1'b0;
            token_value_reg <= 64'd0;
            token_bad_reg   <= 1'b0;
            mpos_reg        <= 2'd0;
            width_reg       <= '0;
            total_reg       <= '0;
            emitted_reg     <= '0;
            cmode_reg       <= CM_NONE;
            tpos_reg        <= 4'd0;
            tag_value_reg   <= 64'd0;
            tag_ok_reg      <= 2'd0;
            bseen_reg       <= 1'b0;
            bval_reg        <= 64'd0;
            tseen_reg       <= 1'b0;
            tval_reg        <= 64'd0;
        end
        else if (go) begin
            phase_reg       <= phase_next;
            in_token_reg    <= in_token_next;
            token_value_reg <= token_value_next;
            token_bad_reg   <= token_bad_next;
            mpos_reg        <= mpos_next;
            width_reg       <= width_next;
            total_reg       <= total_next;
            emitted_reg     <= emitted_next;
            cmode_reg       <= cmode_next;
            tpos_reg        <= tpos_next;
            tag_value_reg   <= tag_value_next;
            tag_ok_reg      <= tag_ok_next;
            bseen_reg       <= bseen_next;
            bval_reg        <= bval_next;
            tseen_reg       <= tseen_next;
            tval_reg        <= tval_next;
        end
    end

endmodule

`default_nettype wire

### design/pptb_outq.sv
// Four-entry result queue: takes up to two results per cycle, gives one.
// Depends on pptb_pkg.
`default_nettype none

module pptb_outq (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push0,
    input  pptb_pkg::pptb_result_t data0,
    input  wire                    push1,
    input  pptb_pkg::pptb_result_t data1,
    output logic                   room,
    output logic                   out_valid,
    input  wire                    out_ready,
    output pptb_pkg::pptb_result_t out_data
);
    import pptb_pkg::*;

    pptb_result_t mem_reg [4];
    logic [1:0]   wr_reg, wr_next;
    logic [1:0]   rd_reg, rd_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         pop;

    assign room      = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = wr_reg + {1'b0, push0} + {1'b0, push1};
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push0)
            mem_reg[wr_reg] <= data0;
        if (push1)
            mem_reg[wr_reg + 2'd1] <= data1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### design/plain_ppm_text_to_bytes_top.sv
// Top level of the plain PPM (P3) text-to-bytes parser: input register,
// parser state and result queue. Depends on pptb_pkg, pptb_parser, pptb_outq.
//
// Usage: feed one text character per request on the input channel
// (text_byte, end_of_text marks the last byte of a frame). Each component of
// the image comes out as a kind 0 request with its value and index; after the
// last component, on a header or component error, or at an early end of
// text, one kind 1 summary carries status, payload_bytes and payload_bits.
// Input after the summary is dropped up to the end_of_text byte, and the
// byte after that starts a new frame.
// A request is first held in the input register, parsed combinationally from it
// once the result queue has room, and written to the result queue; out_valid is
// decoded from the queue count, so it rises once a result is in the queue.
// Throughput: one character per cycle while the queue has room; the byte/character
// state machine updates its state on every accepted byte. A byte that makes two
// results leaves both in the queue to drain, so the input pauses when the
// four-entry result queue holds more than two requests.
// Reset clears all parser state to the start of a frame and empties the
// queue. When the receiver stalls the queue fills, then in_ready drops and
// the held input byte waits.
`default_nettype none

module plain_ppm_text_to_bytes_top #(
    parameter int DIM_BITS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  text_byte,
    input  wire         end_of_text,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        kind,
    output logic [7:0]  component_value,
    output logic [33:0] component_index,
    output logic [2:0]  status,
    output logic [33:0] payload_bytes,
    output logic [36:0] payload_bits
);
    import pptb_pkg::*;

    logic         stg_valid_reg;
    logic [7:0]   stg_byte_reg;
    logic         stg_last_reg;
    logic         room;
    logic         go;
    logic         res0_valid;
    logic         res1_valid;
    pptb_result_t res0;
    pptb_result_t res1;
    pptb_result_t head;

    assign go       = stg_valid_reg && room;
    assign in_ready = !stg_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (in_ready)
            stg_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            stg_byte_reg <= text_byte;
            stg_last_reg <= end_of_text;
        end
    end

    pptb_parser #(
        .DIM_BITS(DIM_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .text_byte   (stg_byte_reg),
        .end_of_text (stg_last_reg),
        .res0_valid  (res0_valid),
        .res0        (res0),
        .res1_valid  (res1_valid),
        .res1        (res1)
    );

    pptb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (go && res0_valid),
        .data0     (res0),
        .push1     (go && res1_valid),
        .data1     (res1),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (head)
    );

    assign kind            = head.kind;
    assign component_value = head.value;
    assign component_index = head.index;
    assign status          = head.status;
    assign payload_bytes   = head.bytes;
    assign payload_bits    = head.bits;

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        (go && res1_valid) |-> res0_valid)
        else $error("second result without first");

    a_second_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (go && res1_valid) |-> (res1.kind == KIND_SUMMARY && res0.kind == KIND_COMP))
        else $error("second result is not a summary after a component");

    a_comp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_COMP) |->
            (status == ST_OK && payload_bytes == 34'd0 && payload_bits == 37'd0))
        else $error("component result with summary fields set");

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for plain_ppm_text_to_bytes_top: drives PPM text frames one character per
// request and checks every result request against a cycle-free parser model kept here.
// Depends on pptb_pkg and the design sources.
`timescale 1ns / 100ps

module tb;
    import pptb_pkg::*;

    localparam int DIMW       = 16;
    localparam int STALL_MAX  = 3000;
    localparam int HOLD_START = 1500;
    localparam int HOLD_LEN   = 300;
    localparam int QUIET_LO   = 300;
    localparam int QUIET_HI   = 1100;
    localparam int RAND_ITEMS = 2000;

    // tag words as raw characters; the bit-count word differs from position ten on
    localparam logic [7:0] TAG_WORD [14] = '{8'h4D, 8'h41, 8'h4B, 8'h4F, 8'h43, 8'h4F, 8'h44,
                                             8'h45, 8'h5F, 8'h42, 8'h59, 8'h54, 8'h45, 8'h53};
    localparam logic [7:0] BITS_TAIL [3] = '{8'h49, 8'h54, 8'h53};

    typedef struct {
        logic [7:0]   b;
        logic         eot;
        bit           typed;
        pptb_result_t exp;
    } text_req_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  text_byte;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [7:0]  component_value;
    logic [33:0] component_index;
    logic [2:0]  status;
    logic [33:0] payload_bytes;
    logic [36:0] payload_bits;

    plain_ppm_text_to_bytes_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .text_byte       (text_byte),
        .end_of_text     (end_of_text),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .component_value (component_value),
        .component_index (component_index),
        .status          (status),
        .payload_bytes   (payload_bytes),
        .payload_bits    (payload_bits)
    );

    text_req_t    text_q[$];
    text_req_t    offered;
    pptb_result_t results_due[$];
    pptb_result_t step_out[$];
    int           errors;
    int           cyc;
    int           stall;
    int           hold_left;

    // parser model state
    phase_t      ph;
    bit          in_tok;
    logic [63:0] tok_val;
    bit          tok_bad;
    logic [1:0]  magic_pos;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [33:0] comps_left;
    cmode_t      cm;
    logic [3:0]  tag_pos;
    logic [63:0] tag_val;
    logic [1:0]  tag_digits;
    bit          bytes_seen;
    logic [63:0] bytes_val;
    bit          bits_seen;
    logic [63:0] bits_val;

    function automatic logic [7:0] tag_char(input bit bits_word, input int pos);
        if (bits_word && pos >= 10)
            return BITS_TAIL[pos - 10];
        return TAG_WORD[pos];
    endfunction

    function automatic bit digit_fits(input logic [63:0] v, input logic [7:0] d);
        return !(v > 64'd1844674407370955161 || (v == 64'd1844674407370955161 && d > 8'd5));
    endfunction

    function automatic logic [63:0] total_comps();
        return {48'd0, img_w} * {48'd0, img_h} * 64'd3;
    endfunction

    task automatic clear_parser();
        ph         = PH_MAGIC;
        in_tok     = 0;
        tok_val    = '0;
        tok_bad    = 0;
        magic_pos  = '0;
        img_w      = '0;
        img_h      = '0;
        comps_left = '0;
        cm         = CM_NONE;
        tag_pos    = '0;
        tag_val    = '0;
        tag_digits = '0;
        bytes_seen = 0;
        bytes_val  = '0;
        bits_seen  = 0;
        bits_val   = '0;
    endtask

    task automatic emit(input logic k, input logic [7:0] v, input logic [63:0] idx,
                        input logic [2:0] st, input logic [63:0] bc, input logic [63:0] ic);
        pptb_result_t r;
        r.kind   = k;
        r.value  = v;
        r.index  = idx[33:0];
        r.status = st;
        r.bytes  = bc[33:0];
        r.bits   = ic[36:0];
        step_out.push_back(r);
    endtask

    task automatic close_frame(input logic [2:0] st_in);
        logic [2:0]  st;
        logic [63:0] bc;
        logic [63:0] ic;
        st = st_in;
        bc = '0;
        ic = '0;
        if (st == ST_OK) begin
            bc = total_comps();
            if (bytes_seen) begin
                if (bytes_val > bc)
                    st = ST_BYTETAG;
                else
                    bc = bytes_val;
            end
            if (st == ST_OK) begin
                if (bits_seen) begin
                    if (bits_val > bc * 64'd8)
                        st = ST_BITTAG;
                    else
                        ic = bits_val;
                end else begin
                    ic = bc * 64'd8;
                end
            end
            if (st != ST_OK) begin
                bc = '0;
                ic = '0;
            end
        end
        ph = PH_DONE;
        emit(KIND_SUMMARY, 8'd0, total_comps() - {30'd0, comps_left}, st, bc, ic);
    endtask

    task automatic finish_token();
        bit dim_ok;
        dim_ok = !tok_bad && tok_val != 0 && tok_val < (64'd1 << DIMW);
        in_tok = 0;
        case (ph)
            PH_MAGIC:
                if (tok_bad || magic_pos != 2'd2)
                    close_frame(ST_MAGIC);
                else
                    ph = PH_WIDTH;
            PH_WIDTH:
                if (!dim_ok) begin
                    close_frame(ST_SIZE);
                end else begin
                    img_w = tok_val[15:0];
                    ph    = PH_HEIGHT;
                end
            PH_HEIGHT:
                if (!dim_ok) begin
                    close_frame(ST_SIZE);
                end else begin
                    img_h      = tok_val[15:0];
                    comps_left = total_comps();
                    ph         = PH_MAXVAL;
                end
            PH_MAXVAL:
                if (tok_bad || tok_val != 64'd255)
                    close_frame(ST_MAXVAL);
                else
                    ph = PH_COMP;
            PH_COMP:
                if (tok_bad || tok_val > 64'd255) begin
                    close_frame(ST_COMP);
                end else begin
                    emit(KIND_COMP, tok_val[7:0], total_comps() - {30'd0, comps_left},
                         ST_OK, 64'd0, 64'd0);
                    comps_left = comps_left - 1;
                    if (comps_left == 0)
                        close_frame(ST_OK);
                end
            default: ;
        endcase
    endtask

    task automatic token_char(input logic [7:0] c);
        if (!in_tok) begin
            in_tok    = 1;
            tok_val   = '0;
            tok_bad   = 0;
            magic_pos = '0;
        end
        if (ph == PH_MAGIC) begin
            if (magic_pos == 2'd0 && c == CH_P)
                magic_pos = 2'd1;
            else if (magic_pos == 2'd1 && c == CH_3)
                magic_pos = 2'd2;
            else
                tok_bad = 1;
        end else if (c >= CH_0 && c <= CH_9) begin
            if (!tok_bad) begin
                if (digit_fits(tok_val, c - CH_0))
                    tok_val = tok_val * 64'd10 + {56'd0, c - CH_0};
                else
                    tok_bad = 1;
            end
        end else begin
            tok_bad = 1;
        end
    endtask

    task automatic commit_tag();
        if (tag_digits == 2'd1) begin
            if (cm == CM_NUM_BYTES) begin
                bytes_seen = 1;
                bytes_val  = tag_val;
            end else if (cm == CM_NUM_BITS) begin
                bits_seen = 1;
                bits_val  = tag_val;
            end
        end
    endtask

    task automatic comment_char(input logic [7:0] c);
        bit blank;
        bit skip;
        int len;
        bit sel;
        blank = (c == CH_SPACE || c == CH_TAB);
        skip  = 0;
        if (cm == CM_LEAD) begin
            if (blank) begin
                skip = 1;
            end else begin
                cm      = CM_PREFIX;
                tag_pos = '0;
            end
        end
        if (!skip) begin
            case (cm)
                CM_PREFIX:
                    if (tag_pos < 4'd10) begin
                        if (c == tag_char(1'b0, tag_pos))
                            tag_pos = tag_pos + 1;
                        else
                            cm = CM_SKIP;
                    end else if (c == CH_Y) begin
                        cm      = CM_BYTES;
                        tag_pos = 4'd11;
                    end else if (c == CH_I) begin
                        cm      = CM_BITS;
                        tag_pos = 4'd11;
                    end else begin
                        cm = CM_SKIP;
                    end
                CM_BYTES, CM_BITS: begin
                    sel = (cm == CM_BITS);
                    len = sel ? 13 : 14;
                    if (tag_pos < len && c == tag_char(sel, tag_pos)) begin
                        tag_pos = tag_pos + 1;
                        if (tag_pos == len) begin
                            cm         = sel ? CM_NUM_BITS : CM_NUM_BYTES;
                            tag_val    = '0;
                            tag_digits = '0;
                        end
                    end else begin
                        cm = CM_SKIP;
                    end
                end
                CM_NUM_BYTES, CM_NUM_BITS:
                    if (c >= CH_0 && c <= CH_9) begin
                        if (tag_digits != 2'd2) begin
                            if (digit_fits(tag_val, c - CH_0)) begin
                                tag_val    = tag_val * 64'd10 + {56'd0, c - CH_0};
                                tag_digits = 2'd1;
                            end else begin
                                tag_digits = 2'd2;
                            end
                        end
                    end else if (!(blank && tag_digits == 2'd0)) begin
                        commit_tag();
                        cm = CM_SKIP;
                    end
                default: ;
            endcase
        end
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last);
        step_out.delete();
        if (ph == PH_DONE) begin
            // drop everything up to the end of the frame
        end else if (cm != CM_NONE) begin
            if (c == CH_LF || c == CH_CR) begin
                commit_tag();
                cm = CM_NONE;
            end else begin
                comment_char(c);
            end
        end else if (c == CH_HASH) begin
            if (in_tok)
                finish_token();
            if (ph != PH_DONE) begin
                cm         = CM_LEAD;
                tag_pos    = '0;
                tag_val    = '0;
                tag_digits = '0;
            end
        end else if (c <= CH_SPACE || c >= CH_HIGH) begin
            if (in_tok)
                finish_token();
        end else begin
            token_char(c);
        end
        if (last) begin
            if (ph != PH_DONE && in_tok)
                finish_token();
            if (ph != PH_DONE)
                close_frame(ST_EARLY);
            clear_parser();
        end
    endtask

    // ---------------- stimulus building ----------------

    task automatic put(input logic [7:0] b, input logic e = 1'b0);
        text_req_t r;
        r.b     = b;
        r.eot   = e;
        r.typed = 0;
        r.exp   = '0;
        text_q.push_back(r);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    task automatic put_num(input logic [63:0] v);
        put_str($sformatf("%0d", v));
    endtask

    task automatic put_gap();
        int n;
        n = 1 + $urandom_range(0, 1);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: put(CH_SPACE);
                1: put(CH_LF);
                2: put(8'($urandom_range(0, 32)));
                default: put(8'($urandom_range(128, 255)));
            endcase
        end
    endtask

    task automatic put_comment(input logic [63:0] total);
        int  k;
        int  len;
        int  badpos;
        bit  bad;
        bit  sel;
        int  t;
        logic [7:0] ch;
        t = (total > 64'd1000) ? 1000 : int'(total);
        put(CH_HASH);
        k = $urandom_range(0, 3);
        repeat ($urandom_range(0, 2))
            put($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        if (k < 3) begin
            sel    = (k == 1);
            len    = sel ? 13 : 14;
            bad    = ($urandom_range(0, 9) == 0);
            badpos = $urandom_range(0, len - 1);
            for (int i = 0; i < len; i++) begin
                ch = tag_char(sel, i);
                if (bad && i == badpos)
                    ch = ch + 8'd1;
                put(ch);
            end
            repeat ($urandom_range(0, 1))
                put(CH_SPACE);
            case ($urandom_range(0, 9))
                0: put_str("18446744073709551615");
                1: put_str("18446744073709551616");
                2: ;
                default: put_num(64'(sel ? $urandom_range(0, t * 8 + 2)
                                         : $urandom_range(0, t + 1)));
            endcase
            case ($urandom_range(0, 2))
                0: put(CH_LF);
                1: put(CH_CR);
                default: put_str("x\n");
            endcase
        end else begin
            repeat ($urandom_range(0, 6))
                put(8'($urandom_range(33, 126)));
            put(CH_LF);
        end
    endtask

    task automatic put_dim(output logic [63:0] v);
        if ($urandom_range(0, 99) < 90) begin
            v = 64'($urandom_range(1, 3));
            put_num(v);
        end else begin
            case ($urandom_range(0, 4))
                0: begin v = 64'd0;     put_str("0"); end
                1: begin v = 64'd65535; put_str("65535"); end
                2: begin v = 64'd65536; put_str("65536"); end
                3: begin v = 64'd0;     put_str("99999999999999999999999"); end
                default: begin v = 64'd2; put_str("00002"); end
            endcase
        end
    endtask

    task automatic build_frame();
        int          start;
        int          cut;
        int          ncomp;
        bit          force_cut;
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] total;
        start = text_q.size();
        if ($urandom_range(0, 99) < 95) begin
            put_str("P3");
        end else begin
            case ($urandom_range(0, 3))
                0: put_str("P4");
                1: put_str("P");
                2: put_str("P33");
                default: put_str("p3");
            endcase
        end
        put_gap();
        if ($urandom_range(0, 99) < 25) put_comment(64'd12);
        put_dim(w);
        put_gap();
        if ($urandom_range(0, 99) < 25) put_comment(64'd12);
        put_dim(h);
        put_gap();
        total = (w == 0 || h == 0 || w > 65535 || h > 65535) ? 64'd0 : w * h * 64'd3;
        if ($urandom_range(0, 99) < 25) put_comment(total);
        if ($urandom_range(0, 99) < 92) begin
            put_str("255");
        end else begin
            case ($urandom_range(0, 2))
                0: put_str("256");
                1: put_str("0255");
                default: put_str("25x");
            endcase
        end
        put_gap();
        force_cut = (total > 12);
        ncomp     = (total == 0 || total > 12) ? 4 : int'(total);
        for (int i = 0; i < ncomp; i++) begin
            if ($urandom_range(0, 99) < 94) begin
                put_num(64'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 3))
                    0: put_str("256");
                    1: put_str("18446744073709551616");
                    2: put_str("7q");
                    default: put_str("000");
                endcase
            end
            put_gap();
            if ($urandom_range(0, 99) < 12) put_comment(total);
        end
        if (force_cut || $urandom_range(0, 99) < 12) begin
            cut = $urandom_range(start, text_q.size() - 1);
            while (text_q.size() > cut + 1)
                void'(text_q.pop_back());
            text_q[$].eot = 1'b1;
        end else begin
            repeat ($urandom_range(0, 3))
                put(8'($urandom_range(0, 255)));
            put(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // directed rows: byte, end of text, typed expectation flag, typed expectation
    localparam int DIR_ROWS = 20;
    text_req_t dir_tab [DIR_ROWS];

    task automatic load_directed();
        text_req_t r;
        logic [7:0] seq [18];
        seq = '{CH_P, CH_3, 8'hFF, 8'h31, 8'h00, 8'h31, CH_SPACE, 8'h32, 8'h35, 8'h35,
                CH_LF, CH_0, CH_TAB, CH_0, CH_HIGH, 8'h32, 8'h35, 8'h35};
        // bad magic token closed by end of text
        r.b = 8'h51; r.eot = 1; r.typed = 1;
        r.exp = '{KIND_SUMMARY, 8'd0, 34'd0, ST_MAGIC, 34'd0, 37'd0};
        dir_tab[0] = r;
        // minimal 1x1 image, last component closed by end of text
        for (int i = 0; i < 18; i++) begin
            r.b = seq[i]; r.eot = (i == 17); r.typed = 0; r.exp = '0;
            dir_tab[1 + i] = r;
        end
        // end of text with no token at all
        r.b = 8'hFF; r.eot = 1; r.typed = 1;
        r.exp = '{KIND_SUMMARY, 8'd0, 34'd0, ST_EARLY, 34'd0, 37'd0};
        dir_tab[19] = r;
        for (int i = 0; i < DIR_ROWS; i++)
            text_q.push_back(dir_tab[i]);
    endtask

    // ---------------- clock, reset, main flow ----------------

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        errors = 0;
        rst_n  = 0;
        clear_parser();
        load_directed();
        while (text_q.size() < DIR_ROWS + RAND_ITEMS)
            build_frame();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        while (text_q.size() > 0 || in_valid)
            @(posedge clk);
        while (results_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk) begin
        cyc <= rst_n ? cyc + 1 : 0;
    end

    // sender: offer the next character, predict on accept
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            text_byte   <= 8'd0;
            end_of_text <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                parse_char(offered.b, offered.eot);
                if (offered.typed)
                    results_due.push_back(offered.exp);
                else
                    foreach (step_out[i]) results_due.push_back(step_out[i]);
            end
            if (!in_valid || in_ready) begin
                if (text_q.size() > 0 &&
                    ((cyc >= QUIET_LO && cyc < QUIET_HI) || $urandom_range(0, 99) >= 24)) begin
                    offered = text_q.pop_front();
                    in_valid    <= 1'b1;
                    text_byte   <= offered.b;
                    end_of_text <= offered.eot;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random idling plus one long hold-off to back up the block
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (cyc == HOLD_START)
                hold_left = HOLD_LEN;
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= (cyc >= QUIET_LO && cyc < QUIET_HI) || $urandom_range(0, 99) >= 24;
            end
        end
    end

    // result checker
    always @(posedge clk) begin
        pptb_result_t e;
        if (rst_n && out_valid && out_ready) begin
            if (results_due.size() == 0) begin
                $error("unexpected result request: kind %0d index %0d", kind, component_index);
                errors++;
            end else begin
                e = results_due.pop_front();
                if (kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, kind); errors++;
                end
                if (component_value !== e.value) begin
                    $error("component_value: expected %0d, got %0d", e.value, component_value);
                    errors++;
                end
                if (component_index !== e.index) begin
                    $error("component_index: expected %0d, got %0d", e.index, component_index);
                    errors++;
                end
                if (status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, status); errors++;
                end
                if (payload_bytes !== e.bytes) begin
                    $error("payload_bytes: expected %0d, got %0d", e.bytes, payload_bytes);
                    errors++;
                end
                if (payload_bits !== e.bits) begin
                    $error("payload_bits: expected %0d, got %0d", e.bits, payload_bits);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no request moving on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall <= 0;
        end else if (stall >= STALL_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall <= stall + 1;
        end
    end

endmodule
